[rtl/core/scc_pkg.sv]
package scc_pkg;

   localparam int CODE_W      = 10;
   localparam int MODE_W      = 2;
   localparam int DUTY_W      = 10;
   localparam int IND_W       = 3;
   localparam int PCT_W       = 12;
   localparam int SOC_W       = 36;
   localparam int SUM_W       = 24;
   localparam int GAIN_W      = 18;
   localparam int OFFSET_W    = 17;
   localparam int CSR_DATA_W  = 18;
   localparam int CSR_INDEX_W = 3;

   // duty codes are scaled from a 10-bit full scale to this resolution
   localparam int DUTY_WIDTH = 10;

   // charge gain is in units of 2^-16 soc lsb
   localparam int GAIN_SHIFT = 16;

   // battery code to percent: code * 3000 / 1023 - 1200
   localparam int CONV_W       = 22;
   localparam int QUOT_W       = 12;
   localparam int CONV_SCALE   = 3000;
   localparam int CODE_FULL    = 1023;
   localparam int CODE_FULL_INV = 3071;
   localparam int PCT_OFFSET   = 1200;

   localparam logic [MODE_W-1:0] MODE_INIT    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CONTROL = 2'd2;

   localparam logic [IND_W-1:0] IND_NONE  = 3'd0;
   localparam logic [IND_W-1:0] IND_BULK  = 3'd1;
   localparam logic [IND_W-1:0] IND_TAPER = 3'd2;
   localparam logic [IND_W-1:0] IND_FULL  = 3'd3;
   localparam logic [IND_W-1:0] IND_LOW   = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_LIMIT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOAT_LIMIT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESUME_LIMIT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARGE_GAIN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARGE_OFFSET = 3'd5;

   localparam logic signed [SOC_W-1:0] SOC_MAX = {1'b0, {(SOC_W-1){1'b1}}};
   localparam logic signed [SOC_W-1:0] SOC_MIN = {1'b1, {(SOC_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [PCT_W-1:0] PCT_MAX = {1'b0, {(PCT_W-1){1'b1}}};
   localparam logic signed [PCT_W-1:0] PCT_MIN = {1'b1, {(PCT_W-1){1'b0}}};

   localparam logic [DUTY_W-1:0] DUTY_920 = DUTY_W'((920 << DUTY_WIDTH) >> CODE_W);
   localparam logic [DUTY_W-1:0] DUTY_910 = DUTY_W'((910 << DUTY_WIDTH) >> CODE_W);
   localparam logic [DUTY_W-1:0] DUTY_818 = DUTY_W'((818 << DUTY_WIDTH) >> CODE_W);
   localparam logic [DUTY_W-1:0] DUTY_716 = DUTY_W'((716 << DUTY_WIDTH) >> CODE_W);
   localparam logic [DUTY_W-1:0] DUTY_613 = DUTY_W'((613 << DUTY_WIDTH) >> CODE_W);
   localparam logic [DUTY_W-1:0] DUTY_511 = DUTY_W'((511 << DUTY_WIDTH) >> CODE_W);
   localparam logic [DUTY_W-1:0] DUTY_409 = DUTY_W'((409 << DUTY_WIDTH) >> CODE_W);
   localparam logic [DUTY_W-1:0] DUTY_306 = DUTY_W'((306 << DUTY_WIDTH) >> CODE_W);
   localparam logic [DUTY_W-1:0] DUTY_204 = DUTY_W'((204 << DUTY_WIDTH) >> CODE_W);
   localparam logic [DUTY_W-1:0] DUTY_102 = DUTY_W'((102 << DUTY_WIDTH) >> CODE_W);

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CODE_W-1:0] battery_code;
      logic [CODE_W-1:0] panel_code;
      logic [CODE_W-1:0] recheck_code;
      logic [CODE_W-1:0] current_code;
      logic [CODE_W-1:0] reference_code;
   } item_type;

   typedef struct packed {
      logic [DUTY_W-1:0]        charge_duty;
      logic [DUTY_W-1:0]        load_duty;
      logic [IND_W-1:0]         indicator;
      logic                     panel_present;
      logic signed [PCT_W-1:0]  soc_percent;
   } result_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_wr_type;

   typedef struct packed {
      logic s2_load;
      logic s3_load;
   } stage_ctl_type;

endpackage

[rtl/core/scc_req_if.sv]
interface scc_req_if import scc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [CODE_W-1:0] battery_code;
   logic [CODE_W-1:0] panel_code;
   logic [CODE_W-1:0] recheck_code;
   logic [CODE_W-1:0] current_code;
   logic [CODE_W-1:0] reference_code;

   modport source (
      output valid, mode, battery_code, panel_code, recheck_code, current_code,
             reference_code,
      input  ready
   );

   modport sink (
      input  valid, mode, battery_code, panel_code, recheck_code, current_code,
             reference_code,
      output ready
   );
endinterface

[rtl/core/scc_rsp_if.sv]
interface scc_rsp_if import scc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [DUTY_W-1:0]       charge_duty;
   logic [DUTY_W-1:0]       load_duty;
   logic [IND_W-1:0]        indicator;
   logic                    panel_present;
   logic signed [PCT_W-1:0] soc_percent;

   modport source (
      output valid, charge_duty, load_duty, indicator, panel_present, soc_percent,
      input  ready
   );

   modport sink (
      input  valid, charge_duty, load_duty, indicator, panel_present, soc_percent,
      output ready
   );
endinterface

[rtl/core/scc_init_conv.sv]
module scc_init_conv import scc_pkg::*; #(
   parameter int SOC_FRACTION_BITS = 24
) (
   input  logic                    clock,
   input  stage_ctl_type           ctl,
   input  logic [CODE_W-1:0]       battery_code,
   output logic signed [SOC_W-1:0] init_soc
);

   localparam int INIT_W = SOC_FRACTION_BITS + QUOT_W + 1;
   localparam int WIDE_W = 48;

   logic [CONV_W-1:0]        num_ff;
   logic [CONV_W-1:0]        num_in;
   logic signed [SOC_W-1:0]  soc_ff;
   logic signed [SOC_W-1:0]  soc_in;

   logic [QUOT_W-1:0]        fold_sum;
   logic [CODE_W-1:0]        rem;
   logic [QUOT_W-1:0]        exact_num;
   logic [2*QUOT_W-1:0]      quot_prod;
   logic [QUOT_W:0]          quot_ofs;
   logic [3*CODE_W-1:0]      rem_rep;
   logic signed [INIT_W-1:0] init_full;
   logic signed [WIDE_W-1:0] init_wide;

   assign num_in = CONV_W'(battery_code) * CONV_W'(CONV_SCALE);

   // remainder by 1023 from folding 10-bit digits, since 1024 = 1 mod 1023
   assign fold_sum = QUOT_W'(num_ff[CONV_W-1:2*CODE_W]) + QUOT_W'(num_ff[2*CODE_W-1:CODE_W])
                   + QUOT_W'(num_ff[CODE_W-1:0]);

   always_comb begin
      if (fold_sum >= QUOT_W'(2 * CODE_FULL)) begin
         rem = CODE_W'(fold_sum - QUOT_W'(2 * CODE_FULL));
      end else if (fold_sum >= QUOT_W'(CODE_FULL)) begin
         rem = CODE_W'(fold_sum - QUOT_W'(CODE_FULL));
      end else begin
         rem = CODE_W'(fold_sum);
      end
   end

   // exact quotient through the inverse of 1023 modulo 4096
   assign exact_num = num_ff[QUOT_W-1:0] - QUOT_W'(rem);
   assign quot_prod = (2*QUOT_W)'(exact_num) * (2*QUOT_W)'(CODE_FULL_INV);
   assign quot_ofs  = {1'b0, quot_prod[QUOT_W-1:0]} - (QUOT_W+1)'(PCT_OFFSET);

   // fraction of rem / 1023 is the 10-bit remainder repeated
   assign rem_rep   = {rem, rem, rem};
   assign init_full = $signed({quot_ofs, rem_rep[3*CODE_W-1 -: SOC_FRACTION_BITS]});
   assign init_wide = WIDE_W'(init_full);

   always_comb begin
      if (init_wide > WIDE_W'(SOC_MAX)) begin
         soc_in = SOC_MAX;
      end else if (init_wide < WIDE_W'(SOC_MIN)) begin
         soc_in = SOC_MIN;
      end else begin
         soc_in = init_wide[SOC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_load) begin
         num_ff <= num_in;
      end
      if (ctl.s3_load) begin
         soc_ff <= soc_in;
      end
   end

   assign init_soc = soc_ff;

endmodule

[rtl/core/scc_core.sv]
module scc_core import scc_pkg::*; #(
   parameter int SOC_FRACTION_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  csr_wr_type              csr,
   input  logic                    fire,
   input  item_type                item,
   input  logic signed [SOC_W-1:0] init_soc,
   output result_type              result
);

   localparam int PROD_W = GAIN_W + 1 + SUM_W;
   localparam int INC_W  = PROD_W - GAIN_SHIFT + 1;
   localparam int DIFF_W = CODE_W + 2;

   localparam logic signed [SOC_W-1:0] SOC_P60 = SOC_W'(64'sd60 <<< SOC_FRACTION_BITS);
   localparam logic signed [SOC_W-1:0] SOC_P65 = SOC_W'(64'sd65 <<< SOC_FRACTION_BITS);
   localparam logic signed [SOC_W-1:0] SOC_P70 = SOC_W'(64'sd70 <<< SOC_FRACTION_BITS);
   localparam logic signed [SOC_W-1:0] SOC_P75 = SOC_W'(64'sd75 <<< SOC_FRACTION_BITS);
   localparam logic signed [SOC_W-1:0] SOC_P80 = SOC_W'(64'sd80 <<< SOC_FRACTION_BITS);
   localparam logic signed [SOC_W-1:0] SOC_P85 = SOC_W'(64'sd85 <<< SOC_FRACTION_BITS);
   localparam logic signed [SOC_W-1:0] SOC_P90 = SOC_W'(64'sd90 <<< SOC_FRACTION_BITS);
   localparam logic signed [SOC_W-1:0] SOC_P93 = SOC_W'(64'sd93 <<< SOC_FRACTION_BITS);
   localparam logic signed [SOC_W-1:0] SOC_P96 = SOC_W'(64'sd96 <<< SOC_FRACTION_BITS);

   logic [CODE_W-1:0]          low_limit_ff, float_limit_ff, resume_limit_ff, panel_limit_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic signed [OFFSET_W-1:0] offset_ff;

   logic signed [SOC_W-1:0]    soc_ff, soc_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [DUTY_W-1:0]          charge_ff, charge_in;
   logic [DUTY_W-1:0]          load_ff, load_in;
   logic [IND_W-1:0]           ind_ff, ind_in;
   logic                       panel_ff, panel_in;

   logic signed [DIFF_W-1:0]   sample_diff;
   logic signed [SUM_W:0]      sum_ext;
   logic signed [SUM_W-1:0]    sum_sat;
   logic signed [PROD_W-1:0]   prod;
   logic signed [INC_W-1:0]    inc;
   logic signed [SOC_W:0]      soc_ext;
   logic signed [SOC_W-1:0]    soc_new;
   logic signed [SOC_W-1:0]    soc_int;
   logic                       panel_now;
   logic                       above_low;
   logic                       below_float;
   logic                       soc_pos;
   logic                       soc_neg;
   logic [DUTY_W-1:0]          charge_base;
   logic [DUTY_W-1:0]          band_charge;
   logic [DUTY_W-1:0]          band_load;
   logic [IND_W-1:0]           band_ind;
   logic [DUTY_W-1:0]          taper_duty;
   logic signed [PCT_W-1:0]    pct;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff    <= CODE_W'(410);
         float_limit_ff  <= CODE_W'(502);
         resume_limit_ff <= CODE_W'(468);
         panel_limit_ff  <= CODE_W'(478);
         gain_ff         <= GAIN_W'(118818);
         offset_ff       <= OFFSET_W'(1362);
      end else if (csr.we) begin
         case (csr.index)
            CSR_LOW_LIMIT:     low_limit_ff    <= csr.wdata[CODE_W-1:0];
            CSR_FLOAT_LIMIT:   float_limit_ff  <= csr.wdata[CODE_W-1:0];
            CSR_RESUME_LIMIT:  resume_limit_ff <= csr.wdata[CODE_W-1:0];
            CSR_PANEL_LIMIT:   panel_limit_ff  <= csr.wdata[CODE_W-1:0];
            CSR_CHARGE_GAIN:   gain_ff         <= csr.wdata[GAIN_W-1:0];
            CSR_CHARGE_OFFSET: offset_ff       <= $signed(csr.wdata[OFFSET_W-1:0]);
            default: ;
         endcase
      end
   end

   // sample accumulation
   assign sample_diff = $signed({1'b0, item.current_code, 1'b0})
                      - $signed({2'b00, item.reference_code});
   assign sum_ext = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(sample_diff);

   always_comb begin
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
         sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_ext[SUM_W-1:0];
      end
   end

   // charge increment and soc update
   assign prod    = PROD_W'($signed({1'b0, gain_ff})) * PROD_W'(sum_ff);
   assign inc     = INC_W'($signed(prod[PROD_W-1:GAIN_SHIFT])) + INC_W'(offset_ff);
   assign soc_ext = (SOC_W+1)'(soc_ff) + (SOC_W+1)'(inc);

   always_comb begin
      if (soc_ext[SOC_W] != soc_ext[SOC_W-1]) begin
         soc_new = soc_ext[SOC_W] ? SOC_MIN : SOC_MAX;
      end else begin
         soc_new = soc_ext[SOC_W-1:0];
      end
   end

   assign panel_now   = item.panel_code >= panel_limit_ff;
   assign above_low   = item.battery_code >= low_limit_ff;
   assign below_float = item.battery_code < float_limit_ff;
   assign soc_neg     = soc_new[SOC_W-1];
   assign soc_pos     = !soc_neg && (soc_new != '0);
   assign charge_base = panel_now ? charge_ff : '0;

   always_comb begin
      if (soc_new < SOC_P65) begin
         taper_duty = DUTY_818;
      end else if (soc_new < SOC_P70) begin
         taper_duty = DUTY_716;
      end else if (soc_new < SOC_P75) begin
         taper_duty = DUTY_613;
      end else if (soc_new < SOC_P80) begin
         taper_duty = DUTY_511;
      end else if (soc_new < SOC_P85) begin
         taper_duty = DUTY_409;
      end else if (soc_new < SOC_P90) begin
         taper_duty = DUTY_306;
      end else if (soc_new < SOC_P93) begin
         taper_duty = DUTY_204;
      end else if (soc_new < SOC_P96) begin
         taper_duty = DUTY_102;
      end else begin
         taper_duty = charge_base;
      end
   end

   // band selection on the updated soc
   always_comb begin
      band_charge = charge_base;
      band_load   = load_ff;
      band_ind    = ind_ff;
      if (soc_pos && above_low) begin
         band_load = DUTY_920;
         if (soc_new <= SOC_P60 && below_float) begin
            band_charge = DUTY_920;
            band_ind    = IND_BULK;
         end else if (soc_new > SOC_P60 && soc_new <= SOC_P96 && below_float) begin
            band_ind    = IND_TAPER;
            band_charge = taper_duty;
         end else begin
            band_charge = '0;
            if (soc_new > SOC_P96) begin
               band_ind = IND_FULL;
            end else if (item.recheck_code < resume_limit_ff) begin
               band_charge = DUTY_910;
            end else begin
               band_ind = IND_FULL;
            end
         end
      end else if (soc_neg || !above_low) begin
         band_ind    = IND_LOW;
         band_charge = DUTY_910;
         band_load   = panel_now ? DUTY_910 : '0;
      end
   end

   assign soc_int = soc_new >>> SOC_FRACTION_BITS;

   always_comb begin
      if (soc_int > SOC_W'(PCT_MAX)) begin
         pct = PCT_MAX;
      end else if (soc_int < SOC_W'(PCT_MIN)) begin
         pct = PCT_MIN;
      end else begin
         pct = soc_int[PCT_W-1:0];
      end
   end

   always_comb begin
      soc_in    = soc_ff;
      sum_in    = sum_ff;
      charge_in = charge_ff;
      load_in   = load_ff;
      ind_in    = ind_ff;
      panel_in  = panel_ff;
      if (fire) begin
         case (item.mode)
            MODE_INIT: begin
               soc_in = init_soc;
            end
            MODE_SAMPLE: begin
               sum_in = sum_sat;
            end
            MODE_CONTROL: begin
               soc_in    = soc_new;
               sum_in    = '0;
               charge_in = band_charge;
               load_in   = band_load;
               ind_in    = band_ind;
               panel_in  = panel_now;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         soc_ff    <= '0;
         sum_ff    <= '0;
         charge_ff <= DUTY_910;
         load_ff   <= '0;
         ind_ff    <= IND_NONE;
         panel_ff  <= 1'b0;
      end else begin
         soc_ff    <= soc_in;
         sum_ff    <= sum_in;
         charge_ff <= charge_in;
         load_ff   <= load_in;
         ind_ff    <= ind_in;
         panel_ff  <= panel_in;
      end
   end

   assign result.charge_duty   = band_charge;
   assign result.load_duty     = band_load;
   assign result.indicator     = band_ind;
   assign result.panel_present = panel_now;
   assign result.soc_percent   = pct;

endmodule

[rtl/core/soc_tracking_charge_controller.sv]
// Solar charge controller with a coulomb-counted state of charge. Each transfer on req_chan
// is one item: mode 0 loads the state of charge from the battery code, mode 1 adds a current
// sample to the running sum, mode 2 runs a control step and gives exactly one transfer on
// rsp_chan with the duties, indicator, panel flag and integer percent; mode 3 is ignored.
// One item is accepted every cycle unless req_chan.ready is low. An item passes an input
// register, a stage that forms battery_code * 3000, and a stage that finishes the divide by
// 1023; a control result enters the result register as the item leaves the last stage.
// The state update (one 18x24 multiply, the saturating add and the band compares) is done
// as the item leaves that stage, so consecutive items see each other's effects. A result
// left waiting on rsp_chan stalls only the control item behind it; up to two more items are
// buffered before req_chan.ready drops. Configuration writes on the csr port take effect at
// once and are meant for when no item is in flight.
module soc_tracking_charge_controller import scc_pkg::*; #(
   parameter int SOC_FRACTION_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   scc_req_if.sink                req_chan,
   scc_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s2_valid_ff, s2_valid_in;
   logic                    s3_valid_ff, s3_valid_in;
   item_type                s1_item_ff, s2_item_ff, s3_item_ff;
   item_type                req_item;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff;
   result_type              result;
   logic signed [SOC_W-1:0] init_soc;
   stage_ctl_type           stage_ctl;
   csr_wr_type              csr;

   logic out_free;
   logic s3_ctrl;
   logic s3_go;
   logic s3_free;
   logic s2_free;
   logic s1_free;
   logic accept;

   assign req_item.mode           = req_chan.mode;
   assign req_item.battery_code   = req_chan.battery_code;
   assign req_item.panel_code     = req_chan.panel_code;
   assign req_item.recheck_code   = req_chan.recheck_code;
   assign req_item.current_code   = req_chan.current_code;
   assign req_item.reference_code = req_chan.reference_code;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // stage flow, each stage moves when the one after it frees up
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s3_ctrl  = s3_item_ff.mode == MODE_CONTROL;
   assign s3_go    = s3_valid_ff && (!s3_ctrl || out_free);
   assign s3_free  = !s3_valid_ff || s3_go;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign accept   = req_chan.valid && s1_free;

   assign stage_ctl.s2_load = s1_valid_ff && s2_free;
   assign stage_ctl.s3_load = s2_valid_ff && s3_free;

   assign req_chan.ready = s1_free;

   assign s1_valid_in  = s1_free ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_free ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = (s3_go && s3_ctrl) ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (stage_ctl.s2_load) begin
         s2_item_ff <= s1_item_ff;
      end
      if (stage_ctl.s3_load) begin
         s3_item_ff <= s2_item_ff;
      end
      if (s3_go && s3_ctrl) begin
         rsp_ff <= result;
      end
   end

   scc_init_conv #(
      .SOC_FRACTION_BITS (SOC_FRACTION_BITS)
   ) u_init_conv (
      .clock        (clock),
      .ctl          (stage_ctl),
      .battery_code (s1_item_ff.battery_code),
      .init_soc     (init_soc)
   );

   scc_core #(
      .SOC_FRACTION_BITS (SOC_FRACTION_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .fire     (s3_go),
      .item     (s3_item_ff),
      .init_soc (init_soc),
      .result   (result)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.charge_duty   = rsp_ff.charge_duty;
   assign rsp_chan.load_duty     = rsp_ff.load_duty;
   assign rsp_chan.indicator     = rsp_ff.indicator;
   assign rsp_chan.panel_present = rsp_ff.panel_present;
   assign rsp_chan.soc_percent   = rsp_ff.soc_percent;

endmodule
